[src/pom_pkg.sv]
// ----------------------------------------------------------------------------
// pom_pkg: shared types and constants of the partitioned queue manager
// Command and status codes, request and response words, the queued
// operation word, the layout sweep signals and the depth select table.
// ----------------------------------------------------------------------------
package pom_pkg;

	// Default sizes handed to the top level parameters.
	localparam int POOL_ENTRIES_DEF = 256;
	localparam int NUM_QUEUES_DEF   = 12;
	localparam int WORD_BITS_DEF    = 64;

	// Fixed field widths.
	localparam int QID_W   = 4;
	localparam int DATA_W  = 64;
	localparam int CNT_W   = 9;
	localparam int DEPTH_W = 9;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;
	localparam int NUM_REGS = 4;

	// Depth of the queue between front and back.
	localparam int FIFO_DEPTH = 2;

	// Depth register indexes.
	localparam logic [1:0] REG_APP_RX = 2'd0;
	localparam logic [1:0] REG_APP_TX = 2'd1;
	localparam logic [1:0] REG_AUX_RX = 2'd2;
	localparam logic [1:0] REG_AUX_TX = 2'd3;

	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 9'd16;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_COUNT = 2'd2,
		CMD_FLUSH = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_ERR   = 2'd2
	} status_t;

	typedef enum logic {
		LAY_IDLE,
		LAY_RUN
	} lay_state_t;

	typedef struct packed {
		cmd_t              command;
		logic [QID_W-1:0]  queue_id;
		logic [DATA_W-1:0] payload;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] read_data;
		logic [CNT_W-1:0]  entry_count;
	} rsp_t;

	// Classified command as it travels from front to back.
	typedef struct packed {
		cmd_t              command;
		logic [QID_W-1:0]  queue_id;
		logic              err;
		logic [DATA_W-1:0] payload;
	} op_t;

	// Queue being placed by the layout pass this cycle.
	typedef struct packed {
		logic             valid;
		logic [QID_W-1:0] idx;
	} layout_sweep_t;

	// Which depth register sizes the region of each queue number.
	function automatic logic [1:0] depth_sel(input logic [QID_W-1:0] q);
		logic [1:0] r;
		unique case (q)
			4'd0:  r = REG_APP_RX;
			4'd1:  r = REG_APP_TX;
			4'd3, 4'd5, 4'd8, 4'd10, 4'd13, 4'd15: r = REG_AUX_TX;
			default: r = REG_AUX_RX;
		endcase
		return r;
	endfunction

endpackage

[src/partitioned_overwrite_queue_manager.sv]
// ----------------------------------------------------------------------------
// partitioned_overwrite_queue_manager: queues sharing one entry pool
// Usage:
//   A command word (req) is taken at a rising edge with start high and busy
//   low. Commands are push, pop, read count and flush on one queue.
//   Every command gives one result word on rsp, marked by done for exactly
//   one cycle; the receiver cannot stall, so there is no backpressure.
//   An accepted command passes a two-word operation queue, then the back end
//   registers its result. A command is accepted every cycle outside a layout
//   pass; the back end retires one per cycle, one pool access and one pointer update.
//   The depth registers sit on the APB port at byte addresses 0, 4, 8, 12.
//   After reset, and after every depth register write, a layout pass places
//   the regions one queue per cycle and empties every queue; busy stays high
//   meanwhile. Depth registers reset to 16.
//   A push into a full queue overwrites its oldest word. Unknown queues and
//   queues whose region does not fit in the pool answer with an error.
// ----------------------------------------------------------------------------
module partitioned_overwrite_queue_manager #(
	parameter int POOL_ENTRIES = pom_pkg::POOL_ENTRIES_DEF,
	parameter int NUM_QUEUES   = pom_pkg::NUM_QUEUES_DEF,
	parameter int WORD_BITS    = pom_pkg::WORD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  pom_pkg::req_t              req,
	output logic                       busy,
	output logic                       done,
	output pom_pkg::rsp_t              rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pom_pkg::APB_AW-1:0] paddr,
	input  logic [pom_pkg::APB_DW-1:0] pwdata,
	output logic [pom_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);

	localparam int PTR_W = $clog2(POOL_ENTRIES);

	logic [PTR_W-1:0]          q_start [NUM_QUEUES];
	logic [PTR_W-1:0]          q_last  [NUM_QUEUES];
	logic [pom_pkg::CNT_W-1:0] q_size  [NUM_QUEUES];
	logic                      q_ok    [NUM_QUEUES];
	pom_pkg::layout_sweep_t    sweep;
	logic [PTR_W-1:0]          sweep_start;
	logic                      lay_busy;
	logic                      op_push, op_pop, fifo_full, fifo_empty;
	pom_pkg::op_t              op_in, op_out;

	// Registers and region layout.
	pom_layout #(
		.POOL_ENTRIES(POOL_ENTRIES),
		.NUM_QUEUES  (NUM_QUEUES)
	) u_layout (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.q_start    (q_start),
		.q_last     (q_last),
		.q_size     (q_size),
		.q_ok       (q_ok),
		.sweep      (sweep),
		.sweep_start(sweep_start),
		.lay_busy   (lay_busy)
	);

	// Command intake and classification.
	pom_front #(
		.NUM_QUEUES(NUM_QUEUES)
	) u_front (
		.start    (start),
		.req      (req),
		.busy     (busy),
		.q_ok     (q_ok),
		.fifo_full(fifo_full),
		.lay_busy (lay_busy),
		.op_push  (op_push),
		.op       (op_in)
	);

	// Operation queue between intake and execution.
	pom_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (op_push),
		.din   (op_in),
		.pop   (op_pop),
		.dout  (op_out),
		.empty (fifo_empty),
		.full  (fifo_full)
	);

	// Execution on pointers, counts and the pool.
	pom_back #(
		.POOL_ENTRIES(POOL_ENTRIES),
		.NUM_QUEUES  (NUM_QUEUES),
		.WORD_BITS   (WORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.sweep      (sweep),
		.sweep_start(sweep_start),
		.q_start    (q_start),
		.q_last     (q_last),
		.q_size     (q_size),
		.op_valid   (!fifo_empty),
		.op         (op_out),
		.op_pop     (op_pop),
		.done       (done),
		.rsp        (rsp)
	);

endmodule

[src/pom_layout.sv]
// ----------------------------------------------------------------------------
// pom_layout: depth registers and region layout
// Holds the four depth registers behind the APB port and, after reset or
// any register write, places the queue regions one queue per cycle.
// ----------------------------------------------------------------------------
module pom_layout #(
	parameter int POOL_ENTRIES = pom_pkg::POOL_ENTRIES_DEF,
	parameter int NUM_QUEUES   = pom_pkg::NUM_QUEUES_DEF,
	localparam int PTR_W = $clog2(POOL_ENTRIES),
	localparam int Q_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pom_pkg::APB_AW-1:0]     paddr,
	input  logic [pom_pkg::APB_DW-1:0]     pwdata,
	output logic [pom_pkg::APB_DW-1:0]     prdata,
	output logic                           pready,
	output logic [PTR_W-1:0]               q_start [NUM_QUEUES],
	output logic [PTR_W-1:0]               q_last  [NUM_QUEUES],
	output logic [pom_pkg::CNT_W-1:0]      q_size  [NUM_QUEUES],
	output logic                           q_ok    [NUM_QUEUES],
	output pom_pkg::layout_sweep_t         sweep,
	output logic [PTR_W-1:0]               sweep_start,
	output logic                           lay_busy
);

	localparam int SUM_W = $clog2(POOL_ENTRIES + 512);

	logic [pom_pkg::DEPTH_W-1:0] depth_q [pom_pkg::NUM_REGS];
	pom_pkg::lay_state_t         state_q, state_d;
	logic [Q_W-1:0]              idx_q;
	logic [SUM_W-1:0]            pos_q;
	logic                        stop_q;
	logic                        cfg_wr;
	logic [1:0]                  reg_idx;
	logic [pom_pkg::DEPTH_W-1:0] dep;
	logic [SUM_W-1:0]            dsz;
	logic [SUM_W-1:0]            sum;
	logic                        fit;
	logic                        at_last;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign prdata  = pom_pkg::APB_DW'(depth_q[reg_idx]);

	// Depth registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pom_pkg::NUM_REGS; i++) depth_q[i] <= pom_pkg::DEPTH_RESET;
		end else if (cfg_wr) begin
			depth_q[reg_idx] <= pwdata[pom_pkg::DEPTH_W-1:0];
		end
	end

	// Region of the queue at the sweep index; a zero depth counts as one.
	always_comb begin
		dep     = depth_q[pom_pkg::depth_sel(pom_pkg::QID_W'(idx_q))];
		dsz     = (dep == '0) ? SUM_W'(1) : SUM_W'(dep);
		sum     = pos_q + dsz;
		fit     = !stop_q && (sum <= SUM_W'(POOL_ENTRIES));
		at_last = (idx_q == Q_W'(NUM_QUEUES - 1));
	end

	assign lay_busy    = (state_q == pom_pkg::LAY_RUN);
	assign sweep.valid = lay_busy;
	assign sweep.idx   = pom_pkg::QID_W'(idx_q);
	assign sweep_start = fit ? pos_q[PTR_W-1:0] : '0;

	// Next state of the layout pass.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pom_pkg::LAY_IDLE: if (cfg_wr) state_d = pom_pkg::LAY_RUN;
			pom_pkg::LAY_RUN: begin
				if (cfg_wr) state_d = pom_pkg::LAY_RUN;
				else if (at_last) state_d = pom_pkg::LAY_IDLE;
			end
			default: state_d = pom_pkg::LAY_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pom_pkg::LAY_RUN;
		else state_q <= state_d;
	end

	// Sweep position and the region table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			pos_q  <= '0;
			stop_q <= 1'b0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				q_start[i] <= '0;
				q_last[i]  <= '0;
				q_size[i]  <= pom_pkg::CNT_W'(1);
				q_ok[i]    <= 1'b0;
			end
		end else if (cfg_wr) begin
			idx_q  <= '0;
			pos_q  <= '0;
			stop_q <= 1'b0;
		end else if (lay_busy) begin
			q_ok[idx_q] <= fit;
			if (fit) begin
				q_start[idx_q] <= pos_q[PTR_W-1:0];
				q_last[idx_q]  <= PTR_W'(sum - SUM_W'(1));
				q_size[idx_q]  <= pom_pkg::CNT_W'(dsz);
				pos_q          <= sum;
			end else begin
				q_start[idx_q] <= '0;
				q_last[idx_q]  <= '0;
				q_size[idx_q]  <= pom_pkg::CNT_W'(1);
				stop_q         <= 1'b1;
			end
			idx_q <= at_last ? '0 : idx_q + Q_W'(1);
		end
	end

endmodule

[src/pom_fifo.sv]
// ----------------------------------------------------------------------------
// pom_fifo: short operation queue
// Holds classified commands between the front and the back.
// ----------------------------------------------------------------------------
module pom_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pom_pkg::op_t  din,
	input  logic          pop,
	output pom_pkg::op_t  dout,
	output logic          empty,
	output logic          full
);

	localparam int PW = (pom_pkg::FIFO_DEPTH > 1) ? $clog2(pom_pkg::FIFO_DEPTH) : 1;
	localparam int CW = $clog2(pom_pkg::FIFO_DEPTH + 1);

	pom_pkg::op_t   mem_q [pom_pkg::FIFO_DEPTH];
	logic [PW-1:0]  wp_q, rp_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push, do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CW'(pom_pkg::FIFO_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rp_q];

	// Storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= din;
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= (wp_q == PW'(pom_pkg::FIFO_DEPTH - 1)) ? '0 : wp_q + PW'(1);
			if (do_pop)
				rp_q <= (rp_q == PW'(pom_pkg::FIFO_DEPTH - 1)) ? '0 : rp_q + PW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + CW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

[src/pom_front.sv]
// ----------------------------------------------------------------------------
// pom_front: command intake
// Accepts commands, marks unknown queues and queues whose region did not fit
// the pool as errors and hands the classified word to the operation queue.
// ----------------------------------------------------------------------------
module pom_front #(
	parameter int NUM_QUEUES = pom_pkg::NUM_QUEUES_DEF,
	localparam int Q_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
	input  logic          start,
	input  pom_pkg::req_t req,
	output logic          busy,
	input  logic          q_ok [NUM_QUEUES],
	input  logic          fifo_full,
	input  logic          lay_busy,
	output logic          op_push,
	output pom_pkg::op_t  op
);

	logic known;

	assign busy    = fifo_full || lay_busy;
	assign op_push = start && !busy;

	// Classify the queue number.
	always_comb begin
		known       = (int'(req.queue_id) < NUM_QUEUES);
		op.command  = req.command;
		op.queue_id = req.queue_id;
		op.payload  = req.payload;
		op.err      = known ? !q_ok[req.queue_id[Q_W-1:0]] : 1'b1;
	end

endmodule

[src/pom_back.sv]
// ----------------------------------------------------------------------------
// pom_back: queue execution
// Carries out one command per cycle while no layout pass runs, on the per-queue
// pointers and counts and on the entry pool, and drives the registered result word.
// ----------------------------------------------------------------------------
module pom_back #(
	parameter int POOL_ENTRIES = pom_pkg::POOL_ENTRIES_DEF,
	parameter int NUM_QUEUES   = pom_pkg::NUM_QUEUES_DEF,
	parameter int WORD_BITS    = pom_pkg::WORD_BITS_DEF,
	localparam int PTR_W = $clog2(POOL_ENTRIES),
	localparam int Q_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pom_pkg::layout_sweep_t    sweep,
	input  logic [PTR_W-1:0]          sweep_start,
	input  logic [PTR_W-1:0]          q_start [NUM_QUEUES],
	input  logic [PTR_W-1:0]          q_last  [NUM_QUEUES],
	input  logic [pom_pkg::CNT_W-1:0] q_size  [NUM_QUEUES],
	input  logic                      op_valid,
	input  pom_pkg::op_t              op,
	output logic                      op_pop,
	output logic                      done,
	output pom_pkg::rsp_t             rsp
);

	logic [PTR_W-1:0]          rp_q  [NUM_QUEUES];
	logic [PTR_W-1:0]          wp_q  [NUM_QUEUES];
	logic [pom_pkg::CNT_W-1:0] cnt_q [NUM_QUEUES];
	logic [WORD_BITS-1:0]      pool  [POOL_ENTRIES];
	logic [WORD_BITS-1:0]      rd_q;

	logic                      exec;
	logic [Q_W-1:0]            qi;
	logic [PTR_W-1:0]          rp, wp, st, lst, rp_adv, wp_adv;
	logic [pom_pkg::CNT_W-1:0] cnt, sz;
	logic [PTR_W-1:0]          rp_nx, wp_nx;
	logic [pom_pkg::CNT_W-1:0] cnt_nx;
	logic                      wr_en, rd_en, hit_nx;
	pom_pkg::status_t          status_nx;

	logic                      valid_s1;
	logic                      hit_s1;
	pom_pkg::status_t          status_s1;
	logic [pom_pkg::CNT_W-1:0] cnt_s1;

	// The layout pass takes the state registers when it runs.
	assign exec   = op_valid && !sweep.valid;
	assign op_pop = exec;

	// Look up the addressed queue and advance its pointers within the region.
	always_comb begin
		qi     = op.queue_id[Q_W-1:0];
		rp     = rp_q[qi];
		wp     = wp_q[qi];
		cnt    = cnt_q[qi];
		st     = q_start[qi];
		lst    = q_last[qi];
		sz     = q_size[qi];
		rp_adv = (rp == lst) ? st : rp + PTR_W'(1);
		wp_adv = (wp == lst) ? st : wp + PTR_W'(1);
	end

	// Command decode.
	always_comb begin
		rp_nx     = rp;
		wp_nx     = wp;
		cnt_nx    = cnt;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		hit_nx    = 1'b0;
		status_nx = pom_pkg::ST_OK;
		if (op.err) begin
			status_nx = pom_pkg::ST_ERR;
			cnt_nx    = '0;
		end else begin
			unique case (op.command)
				pom_pkg::CMD_PUSH: begin
					wr_en = 1'b1;
					wp_nx = wp_adv;
					if (cnt < sz) cnt_nx = cnt + pom_pkg::CNT_W'(1);
					else rp_nx = rp_adv;
				end
				pom_pkg::CMD_POP: begin
					if (cnt != '0) begin
						rd_en  = 1'b1;
						hit_nx = 1'b1;
						rp_nx  = rp_adv;
						cnt_nx = cnt - pom_pkg::CNT_W'(1);
					end else begin
						status_nx = pom_pkg::ST_EMPTY;
					end
				end
				pom_pkg::CMD_COUNT: ;
				pom_pkg::CMD_FLUSH: begin
					rp_nx  = st;
					wp_nx  = st;
					cnt_nx = '0;
				end
				default: ;
			endcase
		end
	end

	// Per-queue pointers and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				rp_q[i]  <= '0;
				wp_q[i]  <= '0;
				cnt_q[i] <= '0;
			end
		end else if (sweep.valid) begin
			rp_q[sweep.idx[Q_W-1:0]]  <= sweep_start;
			wp_q[sweep.idx[Q_W-1:0]]  <= sweep_start;
			cnt_q[sweep.idx[Q_W-1:0]] <= '0;
		end else if (exec && !op.err) begin
			rp_q[qi]  <= rp_nx;
			wp_q[qi]  <= wp_nx;
			cnt_q[qi] <= cnt_nx;
		end
	end

	// Entry pool with a registered read port.
	always_ff @(posedge clk) begin
		if (exec && wr_en) pool[wp] <= op.payload[WORD_BITS-1:0];
		if (exec && rd_en) rd_q <= pool[rp];
	end

	// Result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= exec;
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			hit_s1    <= hit_nx;
			status_s1 <= status_nx;
			cnt_s1    <= cnt_nx;
		end
	end

	assign done            = valid_s1;
	assign rsp.status      = status_s1;
	assign rsp.entry_count = cnt_s1;
	assign rsp.read_data   = hit_s1 ? pom_pkg::DATA_W'(rd_q) : '0;

	// A result word appears only the cycle after a command was carried out.
	a_done_follows_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(exec))
		else $error("result word without an executed command");

	// A push onto a full queue leaves its count at the region size.
	a_full_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		exec && !op.err && op.command == pom_pkg::CMD_PUSH && cnt == sz
		|=> rsp.entry_count == $past(sz))
		else $error("overwriting push changed the count");

	// The layout pass leaves the swept queue empty.
	a_sweep_empties: assert property (@(posedge clk) disable iff (!arst_n)
		sweep.valid |=> cnt_q[$past(sweep.idx[Q_W-1:0])] == '0)
		else $error("layout pass left words in a queue");

endmodule

[verif/tb_partitioned_overwrite_queue_manager.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_partitioned_overwrite_queue_manager: self-checking bench for the queue manager
// Command words are driven from a backlog filled by the sequencing block.
// A local model of the twelve queues predicts the result word of every
// accepted command. The monitor compares each result word with the oldest
// prediction. Depth registers are rewritten over APB between phases.
// ----------------------------------------------------------------------------
module tb_partitioned_overwrite_queue_manager;

	localparam int NQ         = pom_pkg::NUM_QUEUES_DEF;
	localparam int POOL       = pom_pkg::POOL_ENTRIES_DEF;
	localparam int CYCLE_CAP  = 200000;

	logic                         clk     = 1'b0;
	logic                         arst_n  = 1'b0;
	logic                         start   = 1'b0;
	pom_pkg::req_t                req     = '0;
	logic                         busy;
	logic                         done;
	pom_pkg::rsp_t                rsp;
	logic                         psel    = 1'b0;
	logic                         penable = 1'b0;
	logic                         pwrite  = 1'b0;
	logic [pom_pkg::APB_AW-1:0]   paddr   = '0;
	logic [pom_pkg::APB_DW-1:0]   pwdata  = '0;
	logic [pom_pkg::APB_DW-1:0]   prdata;
	logic                         pready;

	// Model of the block: depth registers, region layout, queue state.
	logic [pom_pkg::DEPTH_W-1:0]  depth_reg [pom_pkg::NUM_REGS];
	int unsigned                  region_base [NQ];
	int unsigned                  region_len [NQ];
	bit                           region_ok [NQ];
	int unsigned                  rd_ptr [NQ];
	int unsigned                  wr_ptr [NQ];
	int unsigned                  held [NQ];
	logic [pom_pkg::DATA_W-1:0]   pool_word [POOL];

	pom_pkg::req_t                command_backlog [$];
	pom_pkg::rsp_t                queue_answers [$];
	int                           mismatches = 0;
	int                           gap_left = 0;
	bit                           idle_on = 1'b1;
	bit                           took;
	bit                           take_next = 1'b0;
	pom_pkg::rsp_t                want;
	int                           cycles = 0;

	partitioned_overwrite_queue_manager u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.done    (done),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Free-running clock, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Which depth register sizes the region of a queue number.
	function automatic logic [1:0] region_reg(input int q);
		unique case (q)
			0: return pom_pkg::REG_APP_RX;
			1: return pom_pkg::REG_APP_TX;
			3, 5, 8, 10, 13, 15: return pom_pkg::REG_AUX_TX;
			default: return pom_pkg::REG_AUX_RX;
		endcase
	endfunction

	// Places the regions in queue order and empties every queue.
	function automatic void rebuild_regions();
		int unsigned pos;
		int unsigned d;
		bit stopped;
		pos = 0;
		stopped = 1'b0;
		for (int q = 0; q < NQ; q++) begin
			d = int'(depth_reg[region_reg(q)]);
			if (d == 0)
				d = 1;
			if (!stopped && pos + d <= POOL) begin
				region_ok[q] = 1'b1;
				region_base[q] = pos;
				region_len[q] = d;
				pos += d;
			end else begin
				stopped = 1'b1;
				region_ok[q] = 1'b0;
				region_base[q] = 0;
				region_len[q] = 1;
			end
			rd_ptr[q] = region_base[q];
			wr_ptr[q] = region_base[q];
			held[q] = 0;
		end
	endfunction

	function automatic int unsigned next_slot(input int q, input int unsigned p);
		if (p + 1 >= region_base[q] + region_len[q])
			return region_base[q];
		return p + 1;
	endfunction

	// Applies one command word to the model and returns its result word.
	function automatic pom_pkg::rsp_t serve_command(input pom_pkg::req_t c);
		pom_pkg::rsp_t a;
		int q;
		a = '0;
		a.status = pom_pkg::ST_OK;
		q = int'(c.queue_id);
		if (q >= NQ) begin
			a.status = pom_pkg::ST_ERR;
			return a;
		end
		if (!region_ok[q]) begin
			a.status = pom_pkg::ST_ERR;
			return a;
		end
		unique case (c.command)
			pom_pkg::CMD_PUSH: begin
				pool_word[wr_ptr[q]] = c.payload;
				wr_ptr[q] = next_slot(q, wr_ptr[q]);
				// A full queue loses its oldest word.
				if (held[q] < region_len[q])
					held[q]++;
				else
					rd_ptr[q] = next_slot(q, rd_ptr[q]);
			end
			pom_pkg::CMD_POP: begin
				if (held[q] > 0) begin
					a.read_data = pool_word[rd_ptr[q]];
					rd_ptr[q] = next_slot(q, rd_ptr[q]);
					held[q]--;
				end else begin
					a.status = pom_pkg::ST_EMPTY;
				end
			end
			pom_pkg::CMD_FLUSH: begin
				rd_ptr[q] = region_base[q];
				wr_ptr[q] = region_base[q];
				held[q] = 0;
			end
			default: ;
		endcase
		a.entry_count = pom_pkg::CNT_W'(held[q]);
		return a;
	endfunction

	function automatic void log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH: %s", msg);
	endfunction

	// Handshake sampled at the falling edge before the edge that takes the word.
	always @(negedge clk)
		take_next = start && !busy;

	// Driver: presents backlog words, inserting random idle bursts after acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			gap_left = 0;
		end else begin
			took = take_next;
			if (took)
				queue_answers.push_back(serve_command(req));
			if (took || !start) begin
				if (took && idle_on && $urandom_range(0, 7) == 0)
					gap_left = $urandom_range(1, 12);
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (command_backlog.size() != 0) begin
					start <= 1'b1;
					req <= command_backlog.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: each result word against the oldest prediction, mid-cycle.
	always @(negedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (queue_answers.size() == 0) begin
				log_mismatch($sformatf("result word with none expected: %h", rsp));
			end else begin
				want = queue_answers.pop_front();
				if (rsp.status !== want.status || rsp.read_data !== want.read_data ||
					rsp.entry_count !== want.entry_count)
					log_mismatch($sformatf(
						"status %0d/%0d data %h/%h count %0d/%0d (expected/actual)",
						want.status, rsp.status, want.read_data, rsp.read_data,
						want.entry_count, rsp.entry_count));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_CAP) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic queue_command(input pom_pkg::cmd_t c, input int q,
		input logic [pom_pkg::DATA_W-1:0] w);
		pom_pkg::req_t r;
		r.command = c;
		r.queue_id = q[pom_pkg::QID_W-1:0];
		r.payload = w;
		command_backlog.push_back(r);
	endtask

	function automatic logic [pom_pkg::DATA_W-1:0] random_word();
		unique case ($urandom_range(0, 9))
			0: return '1;
			1: return '0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [pom_pkg::DEPTH_W-1:0] pick_depth();
		unique case ($urandom_range(0, 11))
			0: return 9'd0;
			1: return 9'd256;
			2: return 9'd511;
			3: return pom_pkg::DEPTH_W'($urandom_range(17, 64));
			default: return pom_pkg::DEPTH_W'($urandom_range(1, 8));
		endcase
	endfunction

	// Blocks until every queued word has been taken and answered.
	task automatic wait_idle();
		@(negedge clk);
		while (command_backlog.size() != 0 || start || queue_answers.size() != 0)
			@(negedge clk);
	endtask

	// APB write of one depth register; only issued with the block idle.
	task automatic write_depth(input logic [1:0] idx,
		input logic [pom_pkg::DEPTH_W-1:0] val);
		logic [31:0] filler;
		filler = $urandom;
		@(negedge clk);
		while (busy !== 1'b0)
			@(negedge clk);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {filler[31:pom_pkg::DEPTH_W], val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		depth_reg[idx] = val;
		rebuild_regions();
	endtask

	task automatic write_all(input logic [pom_pkg::DEPTH_W-1:0] a,
		input logic [pom_pkg::DEPTH_W-1:0] b,
		input logic [pom_pkg::DEPTH_W-1:0] c, input logic [pom_pkg::DEPTH_W-1:0] d);
		write_depth(pom_pkg::REG_APP_RX, a);
		write_depth(pom_pkg::REG_APP_TX, b);
		write_depth(pom_pkg::REG_AUX_RX, c);
		write_depth(pom_pkg::REG_AUX_TX, d);
	endtask

	// Mostly push runs followed by pop runs on a few busy queues, some noise.
	task automatic run_traffic(input int total);
		int hot [3];
		int made;
		int q;
		int len;
		int pops;
		@(negedge clk);
		foreach (hot[i])
			hot[i] = $urandom_range(0, NQ - 1);
		made = 0;
		while (made < total) begin
			if ($urandom_range(0, 9) < 7) begin
				q = hot[$urandom_range(0, 2)];
				len = $urandom_range(1, 10);
				pops = $urandom_range(0, len + 2);
				for (int k = 0; k < len; k++)
					queue_command(pom_pkg::CMD_PUSH, q, random_word());
				if ($urandom_range(0, 3) == 0) begin
					queue_command(pom_pkg::CMD_COUNT, q, random_word());
					made++;
				end
				for (int k = 0; k < pops; k++)
					queue_command(pom_pkg::CMD_POP, q, random_word());
				if ($urandom_range(0, 7) == 0) begin
					queue_command(pom_pkg::CMD_FLUSH, q, random_word());
					made++;
				end
				made += len + pops;
			end else begin
				queue_command(pom_pkg::cmd_t'($urandom_range(0, 3)), $urandom_range(0, 15),
					random_word());
				made++;
			end
		end
	endtask

	// Sequencing: reset, directed checks, then random phases over several layouts.
	initial begin
		foreach (depth_reg[i])
			depth_reg[i] = pom_pkg::DEPTH_RESET;
		foreach (pool_word[i])
			pool_word[i] = '0;
		rebuild_regions();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset layout: basic push, pop, empty pop, flush and unknown queues.
		queue_command(pom_pkg::CMD_PUSH, 0, '1);
		queue_command(pom_pkg::CMD_PUSH, 0, '0);
		queue_command(pom_pkg::CMD_COUNT, 0, '1);
		queue_command(pom_pkg::CMD_POP, 0, '0);
		queue_command(pom_pkg::CMD_POP, 0, '1);
		queue_command(pom_pkg::CMD_POP, 0, '0);
		queue_command(pom_pkg::CMD_PUSH, 11, 64'hA5A5_5A5A_0F0F_F0F0);
		queue_command(pom_pkg::CMD_FLUSH, 11, '0);
		queue_command(pom_pkg::CMD_POP, 11, '0);
		queue_command(pom_pkg::CMD_COUNT, 11, '0);
		queue_command(pom_pkg::CMD_PUSH, 12, '1);
		queue_command(pom_pkg::CMD_POP, 13, '0);
		queue_command(pom_pkg::CMD_COUNT, 14, '1);
		queue_command(pom_pkg::CMD_FLUSH, 15, '1);
		wait_idle();

		// Depth one, zero depth read as one, and a region that runs past the pool.
		write_all(9'd1, 9'd0, 9'd256, 9'd16);
		@(negedge clk);
		queue_command(pom_pkg::CMD_PUSH, 0, 64'h0123_4567_89AB_CDEF);
		queue_command(pom_pkg::CMD_PUSH, 0, 64'hFEDC_BA98_7654_3210);
		queue_command(pom_pkg::CMD_COUNT, 0, '0);
		queue_command(pom_pkg::CMD_POP, 0, '0);
		queue_command(pom_pkg::CMD_PUSH, 1, '1);
		queue_command(pom_pkg::CMD_PUSH, 1, '0);
		queue_command(pom_pkg::CMD_POP, 1, '0);
		queue_command(pom_pkg::CMD_PUSH, 2, '1);
		queue_command(pom_pkg::CMD_POP, 3, '0);
		wait_idle();

		// Random phases; the last two run without idle bursts.
		for (int phase = 0; phase < 8; phase++) begin
			unique case (phase)
				0: write_all(9'd1, 9'd1, 9'd1, 9'd1);
				1: write_all(9'd256, 9'd16, 9'd16, 9'd16);
				2: write_all(9'd3, 9'd5, 9'd2, 9'd4);
				default: write_all(pick_depth(), pick_depth(), pick_depth(), pick_depth());
			endcase
			idle_on = (phase < 6);
			run_traffic(60);
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (queue_answers.size() != 0)
			log_mismatch($sformatf("%0d result words never arrived", queue_answers.size()));
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[sim.f]
src/pom_pkg.sv
src/pom_layout.sv
src/pom_fifo.sv
src/pom_front.sv
src/pom_back.sv
src/partitioned_overwrite_queue_manager.sv
verif/tb_partitioned_overwrite_queue_manager.sv
